/* hw/rtl/mcswd_pkg.sv */
// Shared types, field widths and register codes of the multi-channel watchdog.
`default_nettype none

package mcswd_pkg;

	// Field widths of the stream and configuration ports
	localparam int OP_W       = 2;
	localparam int CH_W       = 3;
	localparam int MASK_W     = 6;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;
	localparam int S_DATA_W   = 16;
	localparam int M_DATA_W   = 16;

	// Reset values of the configuration registers
	localparam int unsigned LIMIT_RESET       = 100;
	localparam int unsigned SIGNAL_MASK_RESET = 1;
	localparam int unsigned MOTOR_MASK_RESET  = 0;

	// Number of per-channel limit registers in the register map
	localparam int NUM_LIMIT_REGS = 6;

	// Register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_LIMIT_CH0   = 3'd0,
		REG_LIMIT_CH1   = 3'd1,
		REG_LIMIT_CH2   = 3'd2,
		REG_LIMIT_CH3   = 3'd3,
		REG_LIMIT_CH4   = 3'd4,
		REG_LIMIT_CH5   = 3'd5,
		REG_SIGNAL_MASK = 3'd6,
		REG_MOTOR_MASK  = 3'd7
	} reg_idx_t;

	// Operation codes; the remaining code changes no state
	typedef enum logic [OP_W-1:0] {
		OP_TICK = 2'd0,
		OP_FEED = 2'd1,
		OP_HANG = 2'd2
	} op_t;

	// Command to one channel, already gated by the transfer into the result stage
	typedef struct packed {
		logic tick;
		logic feed;
		logic hang;
	} chan_cmd_t;

endpackage

`default_nettype wire

/* hw/rtl/mcswd_channel.sv */
// One watchdog channel: up-counter, limit compare and error flag.
`default_nettype none

module mcswd_channel #(
	parameter int COUNT_WIDTH = 16
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire mcswd_pkg::chan_cmd_t   cmd,
	input  wire logic [COUNT_WIDTH-1:0] limit,
	output logic                        err_d
);

	logic [COUNT_WIDTH-1:0] count_q;
	logic [COUNT_WIDTH-1:0] count_d;
	logic                   err_q;

	// Advance on a tick while below the limit, otherwise flag; feed and hang load the count
	always_comb begin
		count_d = count_q;
		err_d   = err_q;
		if (cmd.tick) begin
			if (count_q < limit) begin
				count_d = count_q + 1'b1;
				err_d   = 1'b0;
			end else begin
				err_d = 1'b1;
			end
		end else if (cmd.feed) begin
			count_d = '0;
		end else if (cmd.hang) begin
			count_d = limit;
		end
	end

	// Hold the count and error flag; reset leaves the channel expired
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= COUNT_WIDTH'(mcswd_pkg::LIMIT_RESET);
			err_q   <= 1'b1;
		end else begin
			count_q <= count_d;
			err_q   <= err_d;
		end
	end

endmodule

`default_nettype wire

/* hw/rtl/multi_channel_software_watchdog.sv */
// Top level of the multi-channel watchdog: stream stages, register file and status logic.
// An accepted input passes the input stage, then the result stage, which drives m_tvalid.
// Throughput: one transaction per cycle unless m_tready stalls; the channel compare and
// increment paths settle in the cycle that moves an item from input into result stage.
// s_tready falls only when both stages are full and the result is not being taken.
// Reset (arst_n low, asynchronous): both stages empty, every count equal to its limit (100),
// every error flag set, signal mask 1 and motor mask 0.
`default_nettype none

module multi_channel_software_watchdog #(
	parameter int NUM_CHANNELS = 6,
	parameter int COUNT_WIDTH  = 16
) (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	// Input stream
	input  wire logic                             s_tvalid,
	output logic                                  s_tready,
	// s_tdata, from bit 0: channel[2:0], query_mask[8:3], zero fill
	input  wire logic [mcswd_pkg::S_DATA_W-1:0]   s_tdata,
	// s_tuser, from bit 0: operation[1:0]
	input  wire logic [mcswd_pkg::OP_W-1:0]       s_tuser,
	// Result stream
	output logic                                  m_tvalid,
	input  wire logic                             m_tready,
	// m_tdata, from bit 0: error_bits[5:0], any_in_error[6], all_in_error[7],
	// system_okay[8], zero fill
	output logic [mcswd_pkg::M_DATA_W-1:0]        m_tdata,
	// Configuration write port
	input  wire logic                             cfg_we,
	input  wire logic [mcswd_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [mcswd_pkg::CFG_DATA_W-1:0] cfg_data
);

	localparam int MASK_W = mcswd_pkg::MASK_W;
	localparam int CH_W   = mcswd_pkg::CH_W;

	// Bits of the six-bit masks that name an existing channel
	localparam logic [MASK_W-1:0] CHAN_VIEW = (NUM_CHANNELS >= MASK_W) ? {MASK_W{1'b1}} :
		MASK_W'((64'd1 << NUM_CHANNELS) - 64'd1);

	// Input stage
	logic                         valid_s1;
	mcswd_pkg::op_t               op_s1;
	logic [CH_W-1:0]              ch_s1;
	logic [MASK_W-1:0]            qmask_s1;

	// Result stage
	logic                         valid_s2;
	logic [mcswd_pkg::M_DATA_W-1:0] data_s2;

	// Configuration
	logic [COUNT_WIDTH-1:0]       limit_q [NUM_CHANNELS];
	logic [MASK_W-1:0]            signal_mask_q;
	logic [MASK_W-1:0]            motor_mask_q;

	// Channel status
	logic [NUM_CHANNELS-1:0]      err_d;
	logic [MASK_W-1:0]            err_view;
	mcswd_pkg::chan_cmd_t         cmd [NUM_CHANNELS];

	logic                         advance;
	logic                         do_tick;
	logic                         do_feed;
	logic                         do_hang;
	logic [MASK_W-1:0]            qmask;
	logic [MASK_W-1:0]            hit;
	logic                         any_err;
	logic                         all_err;
	logic                         sig_all;
	logic                         mot_any;

	// Move the input stage on whenever the result stage is empty or being drained
	assign advance  = valid_s1 && (!valid_s2 || m_tready);
	assign s_tready = !valid_s1 || advance;
	assign m_tvalid = valid_s2;
	assign m_tdata  = data_s2;

	// Capture accepted input transactions
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			op_s1    <= mcswd_pkg::op_t'(s_tuser);
			ch_s1    <= s_tdata[CH_W-1:0];
			qmask_s1 <= s_tdata[CH_W +: MASK_W];
		end
	end

	// Decode the operation of the item being applied
	always_comb begin
		do_tick = 1'b0;
		do_feed = 1'b0;
		do_hang = 1'b0;
		unique case (op_s1)
			mcswd_pkg::OP_TICK: do_tick = advance;
			mcswd_pkg::OP_FEED: do_feed = advance;
			mcswd_pkg::OP_HANG: do_hang = advance;
			default: ;
		endcase
	end

	// Per-channel limit registers and counters
	for (genvar i = 0; i < NUM_CHANNELS; i++) begin : g_chan
		logic sel;

		assign sel       = (32'(ch_s1) == i);
		assign cmd[i].tick = do_tick;
		assign cmd[i].feed = do_feed && sel;
		assign cmd[i].hang = do_hang && sel;

		if (i < mcswd_pkg::NUM_LIMIT_REGS) begin : g_limit
			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					limit_q[i] <= COUNT_WIDTH'(mcswd_pkg::LIMIT_RESET);
				end else if (cfg_we && (cfg_index == mcswd_pkg::CFG_IDX_W'(i))) begin
					limit_q[i] <= COUNT_WIDTH'(cfg_data);
				end
			end
		end else begin : g_fixed
			// No register in the map: the limit keeps its reset value
			assign limit_q[i] = COUNT_WIDTH'(mcswd_pkg::LIMIT_RESET);
		end

		mcswd_channel #(
			.COUNT_WIDTH(COUNT_WIDTH)
		) u_channel (
			.clk   (clk),
			.arst_n(arst_n),
			.cmd   (cmd[i]),
			.limit (limit_q[i]),
			.err_d (err_d[i])
		);
	end

	// Mask registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			signal_mask_q <= MASK_W'(mcswd_pkg::SIGNAL_MASK_RESET) & CHAN_VIEW;
			motor_mask_q  <= MASK_W'(mcswd_pkg::MOTOR_MASK_RESET);
		end else if (cfg_we) begin
			unique case (cfg_index)
				mcswd_pkg::REG_SIGNAL_MASK: signal_mask_q <= cfg_data[MASK_W-1:0] & CHAN_VIEW;
				mcswd_pkg::REG_MOTOR_MASK:  motor_mask_q  <= cfg_data[MASK_W-1:0] & CHAN_VIEW;
				default: ;
			endcase
		end
	end

	// Six-bit view of the updated error vector; channels beyond it stay internal
	for (genvar j = 0; j < MASK_W; j++) begin : g_view
		if (j < NUM_CHANNELS) begin : g_used
			assign err_view[j] = err_d[j];
		end else begin : g_unused
			assign err_view[j] = 1'b0;
		end
	end

	// Query and system status
	assign qmask   = qmask_s1 & CHAN_VIEW;
	assign hit     = err_view & qmask;
	assign any_err = (hit != '0);
	assign all_err = (hit == qmask);
	assign sig_all = ((err_view & signal_mask_q) == signal_mask_q);
	assign mot_any = ((err_view & motor_mask_q) != '0);

	// Hold the result until the downstream side takes it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (!valid_s2 || m_tready) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			data_s2 <= {{(mcswd_pkg::M_DATA_W - MASK_W - 3){1'b0}},
				!(sig_all || mot_any), all_err, any_err, err_view};
		end
	end

endmodule

`default_nettype wire

/* hw/rtl/mcswd_checker.sv */
// Port-level checks of the multi-channel watchdog, bound to the top level.
`default_nettype none

module mcswd_checker (
	input wire logic                           clk,
	input wire logic                           arst_n,
	input wire logic                           s_tvalid,
	input wire logic                           s_tready,
	input wire logic                           m_tvalid,
	input wire logic                           m_tready,
	input wire logic [mcswd_pkg::M_DATA_W-1:0] m_tdata
);

	// A stalled result stays offered
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid)
		else $error("result transaction dropped while stalled");

	// A stalled result keeps its contents
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> $stable(m_tdata))
		else $error("result transaction changed while stalled");

	// Input backpressure only comes from a stalled result
	assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> m_tvalid && !m_tready)
		else $error("input stalled without output backpressure");

	// A result into an empty output follows an input transaction that passed through the input stage before it rose
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> $past(s_tvalid && s_tready, 2))
		else $error("result appeared without a matching input transaction");

endmodule

bind multi_channel_software_watchdog mcswd_checker u_mcswd_checker (
	.clk     (clk),
	.arst_n  (arst_n),
	.s_tvalid(s_tvalid),
	.s_tready(s_tready),
	.m_tvalid(m_tvalid),
	.m_tready(m_tready),
	.m_tdata (m_tdata)
);

`default_nettype wire
